FILE: src/lir_pkg.sv
// ============================================================================
// lir_pkg - shared types and constants of the linear interpolation resampler
// fixed field widths, phase format, register map and control types
// ============================================================================
package lir_pkg;

    // configuration register widths and reset values
    localparam int unsigned VEL_W       = 13;
    localparam int unsigned CHAN_W      = 2;
    localparam logic [VEL_W-1:0]  VEL_RESET  = 13'd256;
    localparam logic [VEL_W-1:0]  VEL_MIN    = 13'd26;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

    // apb register map, selected by the word address bit
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam logic        REG_VELOCITY = 1'b0;
    localparam logic        REG_CHANNELS = 1'b1;

    // frame counts and phase accumulator
    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned PHASE_FRAC  = 16;
    localparam int unsigned ACC_W       = 32;
    localparam int unsigned OUT_IDX_W   = 20;

    // per-frame output limit
    localparam int unsigned RES_CNT_W   = 5;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS   = 5'd16;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS_L = 5'd15;

    // shared divider geometry
    localparam int unsigned DIV_NUM_W   = 32;
    localparam int unsigned DIV_DEN_W   = 20;
    localparam int unsigned DIV_STEP_W  = 5;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_DIV_M    = 4'b0010,
        ST_DIV_STEP = 4'b0100,
        ST_EMIT     = 4'b1000
    } state_t;

    // control handed to the merge stage together with the lane results
    typedef struct packed {
        logic push;
        logic last;
        logic stereo;
    } out_ctl_t;

endpackage

FILE: src/linear_interp_resampler_core.sv
// ============================================================================
// linear_interp_resampler_core - linear interpolation sample rate converter
// resamples one buffer of mono or stereo frames by the programmed velocity
// ============================================================================
// Frames of one buffer arrive one per transfer; the transfer with tuser set
// starts a buffer and also carries its frame count N. At buffer start the
// block works out M = round(N / velocity) (at least 1) and a Q16.16 phase
// step N/M with one shared iterative divider; a starting frame waits for
// both quotients before its first result. After that each frame is
// accepted in ST_IDLE, then ST_EMIT releases one result per cycle while
// the result side takes them, and a closing step returns to ST_IDLE; on
// the last frame that step carries the final copy. Back pressure on the
// result side stretches this. One interpolation lane per channel computes
// a + (b-a)*frac truncated toward zero; a merge stage packs the lanes into a
// registered result transfer. The last frame is followed by an exact copy
// marked with tlast. Frames past the end of a buffer are dropped, and at most
// 16 results leave per frame. velocity_q8 below 26 acts as 26.
module linear_interp_resampler_core #(
    parameter int unsigned CHANNELS   = 2,
    parameter int unsigned FRAME_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input frames
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_count[15:0], sample_a, sample_b, zero pad to bytes
    input  logic [((16+2*FRAME_BITS+7)/8)*8-1:0] s_tdata,
    // first_frame
    input  logic                                s_tuser,
    // resampled frames
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_a, out_b, zero pad to bytes
    output logic [((2*FRAME_BITS+7)/8)*8-1:0]   m_tdata,
    // last_out
    output logic                                m_tlast,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lir_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lir_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lir_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import lir_pkg::*;

    localparam int unsigned M_DATA_W = ((2*FRAME_BITS+7)/8)*8;
    localparam int unsigned LANES    = (CHANNELS >= 2) ? 2 : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [VEL_W-1:0]  vel_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic              apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg  <= VEL_RESET;
            chan_reg <= CHAN_RESET;
        end else if (apb_wr) begin
            if (paddr[2] == REG_CHANNELS) begin
                chan_reg <= pwdata[CHAN_W-1:0];
            end else begin
                vel_reg <= pwdata[VEL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CHANNELS) ? APB_DATA_W'(chan_reg)
                                               : APB_DATA_W'(vel_reg);

    // stereo needs both the register setting and a second lane
    logic stereo;
    assign stereo = chan_reg[1] && (LANES > 1);

    // ------------------------------------------------------------------
    // input field unpacking
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]           in_count;
    logic signed [FRAME_BITS-1:0] sample_in [LANES];
    logic                         s_xfer;

    assign in_count     = s_tdata[COUNT_W-1:0];
    assign sample_in[0] = s_tdata[COUNT_W +: FRAME_BITS];
    generate
        if (LANES > 1) begin : g_second_in
            assign sample_in[LANES-1] = stereo ? s_tdata[COUNT_W+FRAME_BITS +: FRAME_BITS]
                                               : '0;
        end
    endgenerate

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t                       state_reg, state_next;
    logic [COUNT_W-1:0]           in_index_reg, in_index_next;
    logic [COUNT_W-1:0]           in_total_reg, in_total_next;
    logic [OUT_IDX_W-1:0]         out_index_reg, out_index_next;
    logic [OUT_IDX_W-1:0]         out_total_reg, out_total_next;
    logic [ACC_W-1:0]             phase_acc_reg, phase_acc_next;
    logic [ACC_W-1:0]             phase_step_reg, phase_step_next;
    logic [RES_CNT_W-1:0]         count_reg, count_next;
    logic                         is_last_reg, is_last_next;
    logic signed [FRAME_BITS-1:0] cur_reg  [LANES];
    logic signed [FRAME_BITS-1:0] prev_reg [LANES];
    logic                         load_cur;
    logic                         shift_prev;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // clamped buffer parameters for a starting frame
    logic [COUNT_W-1:0] n_eff;
    logic [VEL_W-1:0]   v_eff;
    assign n_eff = (in_count == '0) ? COUNT_W'(1) : in_count;
    assign v_eff = (vel_reg < VEL_MIN) ? VEL_MIN : vel_reg;

    // shared divider
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [OUT_IDX_W-1:0] m_eff;

    assign m_eff = (div_quot[OUT_IDX_W-1:0] == '0) ? OUT_IDX_W'(1)
                                                    : div_quot[OUT_IDX_W-1:0];

    lir_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // emission decisions for the frame held in cur_reg
    logic [RES_CNT_W-1:0] limit;
    logic                 more;
    logic                 interp;
    logic                 copy_sel;
    logic                 can_push;
    out_ctl_t             out_ctl;

    assign limit  = is_last_reg ? MAX_RESULTS_L : MAX_RESULTS;
    assign more   = (({1'b0, out_index_reg} + (OUT_IDX_W+1)'(1)) < {1'b0, out_total_reg})
                    && (count_reg < limit);
    assign interp = phase_acc_reg[ACC_W-1:PHASE_FRAC] < in_index_reg;
    // outside interpolation the lanes pass the current frame through
    assign copy_sel = !more || !interp;

    always_comb begin
        state_next      = state_reg;
        in_index_next   = in_index_reg;
        in_total_next   = in_total_reg;
        out_index_next  = out_index_reg;
        out_total_next  = out_total_reg;
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        count_next      = count_reg;
        is_last_next    = is_last_reg;
        load_cur        = 1'b0;
        shift_prev      = 1'b0;
        div_start       = 1'b0;
        div_num         = {{(DIV_NUM_W-COUNT_W-9){1'b0}}, n_eff, 9'd0}
                          + DIV_NUM_W'(v_eff);
        div_den         = DIV_DEN_W'({v_eff, 1'b0});
        out_ctl.push    = 1'b0;
        out_ctl.last    = 1'b0;
        out_ctl.stereo  = stereo;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser) begin
                        // new buffer: M = (N*512 + v) / (2v)
                        load_cur       = 1'b1;
                        in_total_next  = n_eff;
                        in_index_next  = '0;
                        out_index_next = '0;
                        phase_acc_next = '0;
                        count_next     = '0;
                        is_last_next   = (n_eff == COUNT_W'(1));
                        div_start      = 1'b1;
                        state_next     = ST_DIV_M;
                    end else if (in_index_reg < in_total_reg) begin
                        load_cur     = 1'b1;
                        count_next   = '0;
                        is_last_next = (({1'b0, in_index_reg} + (COUNT_W+1)'(1))
                                        >= {1'b0, in_total_reg});
                        state_next   = ST_EMIT;
                    end
                end
            end
            ST_DIV_M: begin
                if (div_done) begin
                    // phase step = (N << 16) / M
                    out_total_next = m_eff;
                    div_num        = {in_total_reg, {PHASE_FRAC{1'b0}}};
                    div_den        = DIV_DEN_W'(m_eff);
                    div_start      = 1'b1;
                    state_next     = ST_DIV_STEP;
                end
            end
            ST_DIV_STEP: begin
                if (div_done) begin
                    phase_step_next = div_quot;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                out_ctl.push = more ? (interp || is_last_reg) : is_last_reg;
                out_ctl.last = !more;
                if (!out_ctl.push || can_push) begin
                    if (more && (interp || is_last_reg)) begin
                        out_index_next = out_index_reg + 1'b1;
                        phase_acc_next = phase_acc_reg + phase_step_reg;
                        count_next     = count_reg + 1'b1;
                    end else begin
                        // frame done: final copy already pushed if last
                        if (is_last_reg) begin
                            out_index_next = out_total_reg;
                        end
                        shift_prev    = 1'b1;
                        in_index_next = in_index_reg + 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    out_ctl.push = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_index_reg   <= '0;
            in_total_reg   <= '0;
            out_index_reg  <= '0;
            out_total_reg  <= '0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            count_reg      <= '0;
            is_last_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_index_reg   <= in_index_next;
            in_total_reg   <= in_total_next;
            out_index_reg  <= out_index_next;
            out_total_reg  <= out_total_next;
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            count_reg      <= count_next;
            is_last_reg    <= is_last_next;
        end
    end

    // ------------------------------------------------------------------
    // interpolation lanes, one per channel
    // ------------------------------------------------------------------
    logic signed [FRAME_BITS-1:0] lane_y [LANES];

    generate
        for (genvar i = 0; i < LANES; i++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    prev_reg[i] <= '0;
                end else if (shift_prev) begin
                    prev_reg[i] <= cur_reg[i];
                end
                if (load_cur) begin
                    cur_reg[i] <= sample_in[i];
                end
            end

            lir_lane #(
                .FRAME_BITS (FRAME_BITS)
            ) u_lane (
                .a    (copy_sel ? cur_reg[i] : prev_reg[i]),
                .b    (cur_reg[i]),
                .frac (phase_acc_reg[PHASE_FRAC-1:0]),
                .y    (lane_y[i])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // merge stage and result register
    // ------------------------------------------------------------------
    lir_merge #(
        .FRAME_BITS (FRAME_BITS),
        .LANES      (LANES),
        .M_DATA_W   (M_DATA_W)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (out_ctl),
        .lane_y   (lane_y),
        .ready    (can_push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/lir_div.sv
// ============================================================================
// lir_div - iterative unsigned divider
// restoring radix-2 divider, one quotient bit per cycle, done pulse at the end
// ============================================================================
module lir_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [lir_pkg::DIV_NUM_W-1:0]    dividend,
    input  logic [lir_pkg::DIV_DEN_W-1:0]    divisor,
    output logic                             done,
    output logic [lir_pkg::DIV_NUM_W-1:0]    quotient
);
    import lir_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIV_NUM_W-1:0]  num_reg, num_next;
    logic [DIV_DEN_W-1:0]  den_reg, den_next;
    logic [DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [DIV_DEN_W:0]    trial;
    logic [DIV_DEN_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next  = {num_reg[DIV_NUM_W-2:0], ge};
            rem_next  = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

FILE: src/lir_lane.sv
// ============================================================================
// lir_lane - one channel interpolation lane
// a + (b - a) * frac, truncated toward zero
// ============================================================================
module lir_lane #(
    parameter int unsigned FRAME_BITS = 16
) (
    input  logic signed [FRAME_BITS-1:0]       a,
    input  logic signed [FRAME_BITS-1:0]       b,
    input  logic        [lir_pkg::PHASE_FRAC-1:0] frac,
    output logic signed [FRAME_BITS-1:0]       y
);
    import lir_pkg::*;

    localparam int unsigned PROD_W = FRAME_BITS + PHASE_FRAC + 2;
    localparam int unsigned X_W    = FRAME_BITS + PHASE_FRAC + 3;

    logic signed [FRAME_BITS:0]   diff;
    logic signed [PHASE_FRAC:0]   frac_s;
    logic signed [PROD_W-1:0]     prod;
    logic signed [X_W-1:0]        a_sh;
    logic signed [X_W-1:0]        x;
    logic                         adj;

    assign diff   = {b[FRAME_BITS-1], b} - {a[FRAME_BITS-1], a};
    assign frac_s = {1'b0, frac};
    assign prod   = diff * frac_s;
    assign a_sh   = {{3{a[FRAME_BITS-1]}}, a, {PHASE_FRAC{1'b0}}};
    assign x      = a_sh + {prod[PROD_W-1], prod};

    // floor shift, then step up for negative values with a fraction left
    assign adj = x[X_W-1] & (|x[PHASE_FRAC-1:0]);
    assign y   = x[PHASE_FRAC +: FRAME_BITS] + FRAME_BITS'(adj);

endmodule

FILE: src/lir_merge.sv
// ============================================================================
// lir_merge - merge stage and output register
// packs the lane results into one result transfer and holds it for the sink
// ============================================================================
module lir_merge #(
    parameter int unsigned FRAME_BITS = 16,
    parameter int unsigned LANES      = 2,
    parameter int unsigned M_DATA_W   = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lir_pkg::out_ctl_t            ctl,
    input  logic signed [FRAME_BITS-1:0] lane_y [LANES],
    output logic                         ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [M_DATA_W-1:0]          m_tdata,
    output logic                         m_tlast
);
    import lir_pkg::*;

    logic                  valid_reg;
    logic [M_DATA_W-1:0]   data_reg;
    logic                  last_reg;
    logic [FRAME_BITS-1:0] out_a;
    logic [FRAME_BITS-1:0] out_b;

    assign out_a = lane_y[0];
    assign out_b = (LANES > 1 && ctl.stereo) ? lane_y[LANES-1] : '0;
    assign ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= ctl.push;
        end
        if (ready && ctl.push) begin
            data_reg <= M_DATA_W'({out_b, out_a});
            last_reg <= ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: bench/linear_interp_resampler_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// linear_interp_resampler_core_tb - self-checking bench of the resampler core
// drives buffers of frames and register settings, predicts or types in every
// resampled frame and compares the result stream field by field
// ============================================================================
module linear_interp_resampler_core_tb;
    import lir_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 150;    // divider start-up and a margin
    localparam int unsigned END_CYCLES    = 200;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_FRAMES = 400;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          HOLD_PHASE    = 2;
    localparam int          STEADY_PHASE  = 4;
    localparam int          PREDICTED     = -1;     // row checked against the predictor
    localparam int          DIR_ROWS      = 31;

    localparam logic [APB_ADDR_W-1:0] ADDR_VEL  = {REG_VELOCITY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_CHAN = {REG_CHANNELS, 2'b00};

    typedef struct packed {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
    } out_frame_t;

    typedef enum {ROW_FRAME, ROW_SET_VEL, ROW_SET_CHAN} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               first;
        logic [15:0]        value;      // frame count, or register value
        logic signed [15:0] sa;
        logic signed [15:0] sb;
        int                 n_typed;    // 0 or 1 typed results, or PREDICTED
        logic signed [15:0] ta;
        logic signed [15:0] tb;
        logic               tl;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [47:0]           s_tdata;     // frame_count, sample_a, sample_b
    logic                  s_tuser;     // first_frame
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;     // out_a, out_b
    logic                  m_tlast;     // last_out
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    linear_interp_resampler_core #(
        .CHANNELS   (2),
        .FRAME_BITS (16)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // resampler state as the predictor sees it
    logic [VEL_W-1:0]     vel_cfg   = VEL_RESET;
    logic [CHAN_W-1:0]    chan_cfg  = CHAN_RESET;
    logic signed [15:0]   prev_a    = '0;
    logic signed [15:0]   prev_b    = '0;
    logic [ACC_W-1:0]     acc_q16   = '0;
    logic [ACC_W-1:0]     step_q16  = '0;
    logic [OUT_IDX_W-1:0] out_idx   = '0;
    logic [OUT_IDX_W-1:0] out_total = '0;
    logic [COUNT_W-1:0]   in_idx    = '0;
    logic [COUNT_W-1:0]   in_total  = '0;

    out_frame_t expected_frames[$];

    int  fail_count      = 0;
    int  frames_sent     = 0;
    int  noise_sent      = 0;
    int  buffers_sent    = 0;
    int  results_checked = 0;
    int  settings_made   = 0;
    int  cycle_count     = 0;
    bit  steady          = 1'b0;    // no idling on either side
    bit  hold_off_req    = 1'b0;    // receiver holds off for a long stretch

    // directed stimulus: expectations typed in where obvious
    row_t dir_rows [DIR_ROWS] = '{
        // before any buffer: dropped
        '{ROW_FRAME, 1'b0, 16'h1234,   1234,  -1234, 0, 0, 0, 1'b0},
        // one-frame buffer, copy only
        '{ROW_FRAME, 1'b1, 16'd1,     32767, -32768, 1, 32767, -32768, 1'b1},
        // past the end: dropped
        '{ROW_FRAME, 1'b0, 16'hFFFF,      5,      5, 0, 0, 0, 1'b0},
        // frame count zero acts as one
        '{ROW_FRAME, 1'b1, 16'd0,    -32768,  32767, 1, -32768, 32767, 1'b1},
        // unit speed, full-scale swings
        '{ROW_FRAME, 1'b1, 16'd3,    -32768,  32767, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'hAAAA,  32767, -32768, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h5555,      0,      0, PREDICTED, 0, 0, 1'b0},
        // largest count, abandoned by a restart
        '{ROW_FRAME, 1'b1, 16'hFFFF,    100,   -100, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h0000, -32768,  32767, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b1, 16'd4,         1,      2, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h00FF,     -1,     -2, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'hFF00,  32767,  32767, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h0F0F, -32768, -32768, PREDICTED, 0, 0, 1'b0},
        // slowest speed, mono: last frame overflows its result budget
        '{ROW_SET_VEL,  1'b0, 16'd26, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_SET_CHAN, 1'b0, 16'd1,  0, 0, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b1, 16'd2,     32767, -32768, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h1111, -32768,  32767, PREDICTED, 0, 0, 1'b0},
        // velocity zero clamps to the minimum, channel count zero is mono
        '{ROW_SET_VEL,  1'b0, 16'd0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_SET_CHAN, 1'b0, 16'd0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b1, 16'd3,      -300,   999, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h2222,  20000,  -999, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h3333, -20000,   123, PREDICTED, 0, 0, 1'b0},
        // register maximum, channel count three is stereo: one output frame
        '{ROW_SET_VEL,  1'b0, 16'd8191, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_SET_CHAN, 1'b0, 16'd3,    0, 0, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b1, 16'd3,      7, -7, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h4444,   8, -8, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h8888, -32768, 32767, 1, -32768, 32767, 1'b1},
        // half speed, stereo
        '{ROW_SET_VEL,  1'b0, 16'd128, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_SET_CHAN, 1'b0, 16'd2,   0, 0, 0, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b1, 16'd2,    -1000,  1000, PREDICTED, 0, 0, 1'b0},
        '{ROW_FRAME, 1'b0, 16'h9999,  1001, -1001, PREDICTED, 0, 0, 1'b0}
    };

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // a + (b - a) * frac / 65536, truncated toward zero
    function automatic logic signed [15:0] interp_sample(input logic signed [15:0] a,
                                                         input logic signed [15:0] b,
                                                         input logic [15:0] frac);
        longint x;
        x = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'(frac);
        return 16'(x / 65536);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // output frames released by one accepted input frame
    task automatic resample_frame(input logic first, input logic [15:0] count,
                                  input logic [15:0] sa, input logic [15:0] sb,
                                  output out_frame_t res[$]);
        logic               stereo;
        logic signed [15:0] cur_a;
        logic signed [15:0] cur_b;
        logic [15:0]        n;
        logic [VEL_W-1:0]   v;
        logic [31:0]        m;
        logic               at_end;
        logic [RES_CNT_W-1:0] limit;
        logic [15:0]        lo;
        logic [15:0]        frac;
        res    = {};
        stereo = (chan_cfg >= 2);
        cur_a  = sa;
        cur_b  = stereo ? $signed(sb) : 16'sd0;
        if (first) begin
            n = (count == 16'd0) ? 16'd1 : count;
            v = (vel_cfg < VEL_MIN) ? VEL_MIN : vel_cfg;
            m = (32'(n) * 512 + 32'(v)) / (32'(v) * 2);
            if (m == 0) begin
                m = 1;
            end
            in_total  = n;
            out_total = m[OUT_IDX_W-1:0];
            step_q16  = {n, 16'h0000} / m;
            acc_q16   = '0;
            out_idx   = '0;
            in_idx    = '0;
        end else if (in_idx >= in_total) begin
            return;     // nothing running: frame dropped
        end
        at_end = ({1'b0, in_idx} + 17'd1 >= {1'b0, in_total});
        limit  = at_end ? MAX_RESULTS_L : MAX_RESULTS;
        while (({1'b0, out_idx} + 21'd1 < {1'b0, out_total}) && (res.size() < int'(limit))) begin
            lo   = acc_q16[31:16];
            frac = acc_q16[15:0];
            if (lo < in_idx) begin
                res.push_back('{interp_sample(prev_a, cur_a, frac),
                                stereo ? interp_sample(prev_b, cur_b, frac) : 16'sd0,
                                1'b0});
            end else if (at_end) begin
                res.push_back('{cur_a, cur_b, 1'b0});
            end else begin
                break;
            end
            out_idx++;
            acc_q16 += step_q16;
        end
        if (at_end) begin
            res.push_back('{cur_a, cur_b, 1'b1});
            out_idx = out_total;
        end
        prev_a = cur_a;
        prev_b = cur_b;
        in_idx++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_frame(input logic first, input logic [15:0] count,
                              input logic [15:0] sa, input logic [15:0] sb,
                              input bit use_prediction);
        out_frame_t res[$];
        if (!steady) begin
            while ($urandom_range(0, 99) < 35) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {sb, sa, count};
        do @(posedge aclk); while (!s_tready);
        resample_frame(first, count, sa, sb, res);
        frames_sent++;
        @(negedge aclk);
        if (use_prediction) begin
            foreach (res[i]) expected_frames.push_back(res[i]);
        end
    endtask

    // sender idle until every expected frame is back and the core has settled
    task automatic wait_for_quiet(input int unsigned settle);
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // idle with psel low between accesses
        @(negedge aclk);
    endtask

    task automatic check_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_access(1'b0, addr, '0, got);
        if (got !== want) begin
            $display("%0t: register read at 0x%0h expected 0x%0h actual 0x%0h",
                     $time, addr, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] unused;
        apb_access(1'b1, addr, val, unused);
        if (addr == ADDR_VEL) begin
            vel_cfg = val[VEL_W-1:0];
            check_reg(addr, APB_DATA_W'(vel_cfg));
        end else begin
            chan_cfg = val[CHAN_W-1:0];
            check_reg(addr, APB_DATA_W'(chan_cfg));
        end
        settings_made++;
    endtask

    // result side: compare each transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_frame_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected output frame a=%0d b=%0d last=%0b", $time,
                         $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                fail_count++;
            end else begin
                want = expected_frames.pop_front();
                results_checked++;
                if (m_tdata[15:0] !== want.a) begin
                    $display("%0t: out_a expected %0d actual %0d", $time,
                             want.a, $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[31:16] !== want.b) begin
                    $display("%0t: out_b expected %0d actual %0d", $time,
                             want.b, $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_out expected %0b actual %0b", $time, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random back pressure, one long hold-off on request
    initial begin : receiver
        int hold_count;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_count++;
                end
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d output frames outstanding", $time,
                     expected_frames.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int          ph;
        int          nbuf;
        int          cut;
        int          neff;
        int          rand_frames;
        bit          last_buf;
        logic [15:0] n;
        logic [12:0] vel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_reg(ADDR_VEL, APB_DATA_W'(VEL_RESET));
        check_reg(ADDR_CHAN, APB_DATA_W'(CHAN_RESET));

        // directed table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_SET_VEL: begin
                    wait_for_quiet(SETTLE_CYCLES);
                    write_reg(ADDR_VEL, APB_DATA_W'(dir_rows[i].value));
                end
                ROW_SET_CHAN: begin
                    wait_for_quiet(SETTLE_CYCLES);
                    write_reg(ADDR_CHAN, APB_DATA_W'(dir_rows[i].value));
                end
                default: begin
                    send_frame(dir_rows[i].first, dir_rows[i].value, dir_rows[i].sa,
                               dir_rows[i].sb, dir_rows[i].n_typed == PREDICTED);
                    if (dir_rows[i].n_typed == 1) begin
                        expected_frames.push_back('{dir_rows[i].ta, dir_rows[i].tb,
                                                    dir_rows[i].tl});
                    end
                    if (dir_rows[i].first) begin
                        buffers_sent++;
                    end
                end
            endcase
        end

        // random phases: velocity and channel settings, then three to six buffers
        ph = 0;
        rand_frames = 0;
        while (rand_frames < RANDOM_FRAMES) begin
            case ($urandom_range(0, 9))
                0:       vel = 13'($urandom_range(0, 26));
                1:       vel = 13'($urandom_range(2048, 8191));
                2, 3:    vel = 13'($urandom_range(26, 4096));
                default: vel = 13'($urandom_range(26, 400));
            endcase
            if (ph == HOLD_PHASE) begin
                vel = VEL_MIN;      // many outputs per frame, so the core backs up
            end
            wait_for_quiet(SETTLE_CYCLES);
            write_reg(ADDR_VEL, APB_DATA_W'(vel));
            write_reg(ADDR_CHAN, APB_DATA_W'($urandom_range(0, 3)));
            steady = (ph == STEADY_PHASE);
            if (ph == HOLD_PHASE) begin
                hold_off_req = 1'b1;
            end
            nbuf = $urandom_range(3, 6);
            for (int b = 0; b < nbuf; b++) begin
                last_buf = (b == nbuf - 1);
                if (!last_buf && $urandom_range(0, 9) == 0) begin
                    // any count at all, cut short by the next buffer
                    n   = 16'($urandom);
                    cut = $urandom_range(1, 4);
                end else begin
                    n   = 16'($urandom_range(1, 12));
                    cut = n;
                    if (!last_buf && $urandom_range(0, 7) == 0) begin
                        cut = $urandom_range(1, n);
                    end
                end
                neff = (n == 16'd0) ? 1 : int'(n);
                if (cut > neff) begin
                    cut = neff;
                end
                for (int f = 0; f < cut; f++) begin
                    send_frame(f == 0, (f == 0) ? n : 16'($urandom), pick_sample(),
                               pick_sample(), 1'b1);
                    rand_frames++;
                end
                // stray frames after a finished buffer
                if (cut == neff && $urandom_range(0, 99) < 15) begin
                    repeat ($urandom_range(1, 2)) begin
                        send_frame(1'b0, 16'($urandom), pick_sample(), pick_sample(), 1'b1);
                        noise_sent++;
                    end
                end
                buffers_sent++;
            end
            ph++;
        end
        steady = 1'b0;

        wait_for_quiet(END_CYCLES);
        $display("covered %0d input frames (%0d stray) in %0d buffers over %0d register writes",
                 frames_sent, noise_sent, buffers_sent, settings_made);
        $display("checked %0d output frames across %0d random phases", results_checked, ph);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
